/* rtl/core/bayer_bilinear_demosaic_top_assert.svh */
// Assertion macros shared by the demosaic RTL.
// Used by bayer_bilinear_demosaic_top; no other dependencies.
`ifndef BAYER_BILINEAR_DEMOSAIC_TOP_ASSERT_SVH
`define BAYER_BILINEAR_DEMOSAIC_TOP_ASSERT_SVH

// condition holds at every clock edge outside reset
`define BBD_ASSERT_HOLDS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define BBD_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define BBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/bbd_pkg.sv */
// Shared types, constants and color-filter tables for the Bayer demosaic.
// No dependencies; used by every module of the block.
`default_nettype none

package bbd_pkg;

   // data widths
   localparam int PIXEL_W        = 8;
   localparam int LINE_WIDTH_W   = 12;
   localparam int FRAME_HEIGHT_W = 13;
   localparam int PHASE_W        = 2;

   // default sizes
   localparam int MAX_WIDTH_DEF  = 2048;
   localparam int MAX_HEIGHT_DEF = 4096;

   // interior window: first usable counter value and trailing margin
   localparam int EDGE_MIN  = 3;
   localparam int EDGE_TAIL = 2;

   // register file
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;
   localparam logic [1:0] REG_LINE_WIDTH   = 2'd0;
   localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [1:0] REG_BAYER_PHASE  = 2'd2;

   localparam logic [LINE_WIDTH_W-1:0]   LINE_WIDTH_RST   = 12'd640;
   localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 13'd480;
   localparam logic [PHASE_W-1:0]        BAYER_PHASE_RST  = 2'd0;

   // color-filter site offsets, bit p for phase p
   localparam logic [3:0] RED_SX    = 4'b0101;
   localparam logic [3:0] RED_SY    = 4'b1100;
   localparam logic [3:0] BLUE_SX   = 4'b1010;
   localparam logic [3:0] BLUE_SY   = 4'b0011;
   localparam logic [3:0] GREEN_PAR = 4'b0110;

   typedef struct packed {
      logic [LINE_WIDTH_W-1:0]   line_width;
      logic [FRAME_HEIGHT_W-1:0] frame_height;
      logic [PHASE_W-1:0]        bayer_phase;
   } cfg_type;

   typedef struct packed {
      logic               shift;
      logic               col_odd;
      logic               row_odd;
      logic [PHASE_W-1:0] phase;
   } win_ctl_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] blue;
      logic [PIXEL_W-1:0] green;
      logic [PIXEL_W-1:0] red;
   } rgb_type;

endpackage

`default_nettype wire

/* rtl/core/bbd_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// Depends on bbd_pkg for default sizes.
`default_nettype none

module bbd_ram #(
   parameter int WIDTH = bbd_pkg::PIXEL_W,
   parameter int DEPTH = bbd_pkg::MAX_WIDTH_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

/* rtl/core/bbd_csr.sv */
// Configuration registers behind an APB-style port.
// Depends on bbd_pkg for register codes, widths and reset values.
`default_nettype none

module bbd_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [bbd_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [bbd_pkg::CSR_DATA_W-1:0]  pwdata,
   output      logic [bbd_pkg::CSR_DATA_W-1:0]  prdata,
   output      logic                            pready,
   output      bbd_pkg::cfg_type                cfg
);

   bbd_pkg::cfg_type cfg_ff, cfg_in;
   logic             wr_en;
   logic [1:0]       reg_sel;

   assign pready  = 1'b1;
   assign reg_sel = paddr[3:2];
   assign wr_en   = psel & penable & pwrite & pready;
   assign cfg     = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            bbd_pkg::REG_LINE_WIDTH: begin
               cfg_in.line_width = pwdata[bbd_pkg::LINE_WIDTH_W-1:0];
            end
            bbd_pkg::REG_FRAME_HEIGHT: begin
               cfg_in.frame_height = pwdata[bbd_pkg::FRAME_HEIGHT_W-1:0];
            end
            bbd_pkg::REG_BAYER_PHASE: begin
               cfg_in.bayer_phase = pwdata[bbd_pkg::PHASE_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_width   <= bbd_pkg::LINE_WIDTH_RST;
         cfg_ff.frame_height <= bbd_pkg::FRAME_HEIGHT_RST;
         cfg_ff.bayer_phase  <= bbd_pkg::BAYER_PHASE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      case (reg_sel)
         bbd_pkg::REG_LINE_WIDTH: begin
            prdata = bbd_pkg::CSR_DATA_W'(cfg_ff.line_width);
         end
         bbd_pkg::REG_FRAME_HEIGHT: begin
            prdata = bbd_pkg::CSR_DATA_W'(cfg_ff.frame_height);
         end
         bbd_pkg::REG_BAYER_PHASE: begin
            prdata = bbd_pkg::CSR_DATA_W'(cfg_ff.bayer_phase);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/core/bbd_window.sv */
// 3x3 pixel window and bilinear color interpolation.
// Depends on bbd_pkg for the control and color types and filter tables.
`default_nettype none

module bbd_window (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire bbd_pkg::win_ctl_type         ctl,
   input  wire logic [bbd_pkg::PIXEL_W-1:0]  top,
   input  wire logic [bbd_pkg::PIXEL_W-1:0]  mid,
   input  wire logic [bbd_pkg::PIXEL_W-1:0]  px,
   output      bbd_pkg::rgb_type             rgb
);

   // rows: 0 two lines back, 1 previous line, 2 current line
   // columns: 0 oldest, 2 newest
   logic [bbd_pkg::PIXEL_W-1:0] win_ff [3][3];
   logic [bbd_pkg::PIXEL_W-1:0] win_in [3][3];

   logic [bbd_pkg::PIXEL_W:0]   sum_vert, sum_horz;
   logic [bbd_pkg::PIXEL_W+1:0] sum_diag, sum_cross;
   logic [bbd_pkg::PIXEL_W-1:0] avg_vert, avg_horz, avg_diag, avg_cross, center;
   logic                        red_lx, red_ly, blue_lx, blue_ly, green_site;

   function automatic logic [bbd_pkg::PIXEL_W-1:0] pick(
      input logic                        lx,
      input logic                        ly,
      input logic [bbd_pkg::PIXEL_W-1:0] c,
      input logic [bbd_pkg::PIXEL_W-1:0] v,
      input logic [bbd_pkg::PIXEL_W-1:0] h,
      input logic [bbd_pkg::PIXEL_W-1:0] d
   );
      logic [bbd_pkg::PIXEL_W-1:0] r;
      if (!lx && !ly) begin
         r = c;
      end else if (!lx) begin
         r = v;
      end else if (!ly) begin
         r = h;
      end else begin
         r = d;
      end
      return r;
   endfunction

   // window after this transfer's shift
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         win_in[k][0] = win_ff[k][1];
         win_in[k][1] = win_ff[k][2];
      end
      win_in[0][2] = top;
      win_in[1][2] = mid;
      win_in[2][2] = px;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[k][j] <= '0;
            end
         end
      end else if (ctl.shift) begin
         win_ff <= win_in;
      end
   end

   // neighbor means, truncated
   always_comb begin
      center    = win_in[1][1];
      sum_vert  = {1'b0, win_in[0][1]} + {1'b0, win_in[2][1]};
      sum_horz  = {1'b0, win_in[1][0]} + {1'b0, win_in[1][2]};
      sum_diag  = {2'b00, win_in[0][0]} + {2'b00, win_in[2][0]}
                + {2'b00, win_in[0][2]} + {2'b00, win_in[2][2]};
      sum_cross = {2'b00, win_in[0][1]} + {2'b00, win_in[2][1]}
                + {2'b00, win_in[1][0]} + {2'b00, win_in[1][2]};
      avg_vert  = sum_vert[bbd_pkg::PIXEL_W:1];
      avg_horz  = sum_horz[bbd_pkg::PIXEL_W:1];
      avg_diag  = sum_diag[bbd_pkg::PIXEL_W+1:2];
      avg_cross = sum_cross[bbd_pkg::PIXEL_W+1:2];
   end

   // site offsets from the filter phase
   always_comb begin
      red_lx     = ctl.col_odd ^ bbd_pkg::RED_SX[ctl.phase];
      red_ly     = ctl.row_odd ^ bbd_pkg::RED_SY[ctl.phase];
      blue_lx    = ctl.col_odd ^ bbd_pkg::BLUE_SX[ctl.phase];
      blue_ly    = ctl.row_odd ^ bbd_pkg::BLUE_SY[ctl.phase];
      green_site = (ctl.col_odd ^ ctl.row_odd) == bbd_pkg::GREEN_PAR[ctl.phase];
      rgb.red    = pick(red_lx, red_ly, center, avg_vert, avg_horz, avg_diag);
      rgb.blue   = pick(blue_lx, blue_ly, center, avg_vert, avg_horz, avg_diag);
      rgb.green  = green_site ? center : avg_cross;
   end

endmodule

`default_nettype wire

/* rtl/core/bayer_bilinear_demosaic_top.sv */
// Bilinear Bayer demosaic: position counters, line-store pipeline, output queue.
// Depends on bbd_pkg, bbd_ram, bbd_csr, bbd_window and the assertion header.
//
//   channel  | dir | handshake        | payload
//   req      | in  | req_valid/stall  | raw_pixel, frame_start
//   rsp      | out | rsp_valid/stall  | blue, green, red, out_col, out_row, frame_end
//   csr      | in  | psel/penable     | paddr, pwdata, prdata (pready tied high)
//
// One pixel per clock while req_stall is low. A pixel reads both line stores at its
// column on the transfer edge and writes them back from the stage-1 registers once
// the queue has room; the next accepted pixel at the same column takes the written
// values through a bypass. An interior pixel's result passes from the stage-1
// registers into a two-entry output queue, which drives rsp_valid. That queue absorbs
// rsp_stall; req_stall rises only when it is full. Synchronous reset clears counters,
// window and queue; line stores need no clearing.
`default_nettype none

`include "bayer_bilinear_demosaic_top_assert.svh"

module bayer_bilinear_demosaic_top #(
   parameter int MAX_WIDTH  = bbd_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bbd_pkg::MAX_HEIGHT_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // input channel
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire logic [bbd_pkg::PIXEL_W-1:0]         req_raw_pixel,
   input  wire logic                                req_frame_start,
   // result channel
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      logic [bbd_pkg::PIXEL_W-1:0]         rsp_blue,
   output      logic [bbd_pkg::PIXEL_W-1:0]         rsp_green,
   output      logic [bbd_pkg::PIXEL_W-1:0]         rsp_red,
   output      logic [$clog2(MAX_WIDTH)-1:0]        rsp_out_col,
   output      logic [$clog2(MAX_HEIGHT)-1:0]       rsp_out_row,
   output      logic                                rsp_frame_end,
   // configuration port
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [bbd_pkg::CSR_ADDR_W-1:0]      paddr,
   input  wire logic [bbd_pkg::CSR_DATA_W-1:0]      pwdata,
   output      logic [bbd_pkg::CSR_DATA_W-1:0]      prdata,
   output      logic                                pready
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int PW  = bbd_pkg::PIXEL_W;
   localparam int WEW = ((bbd_pkg::LINE_WIDTH_W > CW) ? bbd_pkg::LINE_WIDTH_W : CW) + 2;
   localparam int HEW = ((bbd_pkg::FRAME_HEIGHT_W > RW) ? bbd_pkg::FRAME_HEIGHT_W : RW) + 2;

   typedef struct packed {
      logic [PW-1:0] blue;
      logic [PW-1:0] green;
      logic [PW-1:0] red;
      logic [CW-1:0] col;
      logic [RW-1:0] row;
      logic          fend;
   } rsp_item_type;

   bbd_pkg::cfg_type     cfg;
   bbd_pkg::win_ctl_type win_ctl;
   bbd_pkg::rgb_type     rgb;

   // position counters
   logic [CW-1:0]  col_ff, col_in;
   logic [RW-1:0]  row_ff, row_in;
   logic [CW-1:0]  c_cur;
   logic [RW-1:0]  r_cur;
   logic [WEW-1:0] w_eff, lw_ext, c_ext, c_p1, c_p2;
   logic [HEW-1:0] h_eff, fh_ext, r_ext, r_p1, r_p2;
   logic           interior, last_px;

   // pipeline control
   logic           en, accept, fwd_hit, push, pop;

   // stage 1: line-store data arrives
   logic           s1_valid_ff, fwd_ff;
   logic [CW-1:0]  s1_addr_ff, s1_cc_ff;
   logic [RW-1:0]  s1_rr_ff;
   logic [PW-1:0]  s1_px_ff, fwd_top_ff, fwd_mid_ff;
   logic           s1_emit_ff, s1_fend_ff;
   logic [PW-1:0]  rd_a, rd_b, top_eff, mid_eff;

   // output queue
   rsp_item_type   q_ff [2];
   rsp_item_type   q_item;
   logic           q_wr_ff, q_rd_ff;
   logic [1:0]     q_cnt_ff, q_cnt_in;

   bbd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // handshake: hold everything while the queue is full
   assign en        = (q_cnt_ff != 2'd2);
   assign req_stall = ~en;
   assign accept    = req_valid & en;

   // current position, frame_start restarts at the origin
   assign c_cur = req_frame_start ? '0 : col_ff;
   assign r_cur = req_frame_start ? '0 : row_ff;

   // effective frame size and interior test
   always_comb begin
      lw_ext   = WEW'(cfg.line_width);
      fh_ext   = HEW'(cfg.frame_height);
      w_eff    = (lw_ext > WEW'(MAX_WIDTH)) ? WEW'(MAX_WIDTH) : lw_ext;
      h_eff    = (fh_ext > HEW'(MAX_HEIGHT)) ? HEW'(MAX_HEIGHT) : fh_ext;
      c_ext    = WEW'(c_cur);
      r_ext    = HEW'(r_cur);
      c_p1     = c_ext + WEW'(1);
      c_p2     = c_ext + WEW'(bbd_pkg::EDGE_TAIL);
      r_p1     = r_ext + HEW'(1);
      r_p2     = r_ext + HEW'(bbd_pkg::EDGE_TAIL);
      interior = (c_ext >= WEW'(bbd_pkg::EDGE_MIN)) && (c_p2 <= w_eff)
              && (r_ext >= HEW'(bbd_pkg::EDGE_MIN)) && (r_p2 <= h_eff);
      last_px  = (c_p2 == w_eff) && (r_p2 == h_eff);
   end

   // counter advance
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (c_p1 >= w_eff) begin
            col_in = '0;
            row_in = (r_p1 >= h_eff) ? '0 : r_cur + RW'(1);
         end else begin
            col_in = c_cur + CW'(1);
            row_in = r_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // line stores: a holds the previous line, b the one before
   bbd_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_line_a (
      .clock    (clock),
      .we       (s1_valid_ff & en),
      .waddr    (s1_addr_ff),
      .wdata    (s1_px_ff),
      .re       (accept),
      .raddr    (c_cur),
      .rdata_ff (rd_a)
   );

   bbd_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_line_b (
      .clock    (clock),
      .we       (s1_valid_ff & en),
      .waddr    (s1_addr_ff),
      .wdata    (mid_eff),
      .re       (accept),
      .raddr    (c_cur),
      .rdata_ff (rd_b)
   );

   // bypass when the write-back hits the column being read
   assign fwd_hit = s1_valid_ff & (s1_addr_ff == c_cur);
   assign top_eff = fwd_ff ? fwd_top_ff : rd_b;
   assign mid_eff = fwd_ff ? fwd_mid_ff : rd_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= accept;
         fwd_ff      <= accept & fwd_hit;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_addr_ff <= c_cur;
         s1_px_ff   <= req_raw_pixel;
         s1_emit_ff <= interior;
         s1_fend_ff <= last_px;
         s1_cc_ff   <= c_cur - CW'(1);
         s1_rr_ff   <= r_cur - RW'(1);
         fwd_top_ff <= mid_eff;
         fwd_mid_ff <= s1_px_ff;
      end
   end

   // window and interpolation
   always_comb begin
      win_ctl.shift   = s1_valid_ff & en;
      win_ctl.col_odd = s1_cc_ff[0];
      win_ctl.row_odd = s1_rr_ff[0];
      win_ctl.phase   = cfg.bayer_phase;
   end

   bbd_window u_window (
      .clock (clock),
      .reset (reset),
      .ctl   (win_ctl),
      .top   (top_eff),
      .mid   (mid_eff),
      .px    (s1_px_ff),
      .rgb   (rgb)
   );

   // output queue
   assign push = s1_valid_ff & s1_emit_ff & en;
   assign pop  = rsp_valid & ~rsp_stall;

   always_comb begin
      q_item.blue  = rgb.blue;
      q_item.green = rgb.green;
      q_item.red   = rgb.red;
      q_item.col   = s1_cc_ff;
      q_item.row   = s1_rr_ff;
      q_item.fend  = s1_fend_ff;
      q_cnt_in     = q_cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_cnt_ff <= '0;
         q_wr_ff  <= 1'b0;
         q_rd_ff  <= 1'b0;
      end else begin
         q_cnt_ff <= q_cnt_in;
         if (push) begin
            q_wr_ff <= ~q_wr_ff;
         end
         if (pop) begin
            q_rd_ff <= ~q_rd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[q_wr_ff] <= q_item;
      end
   end

   assign rsp_valid     = (q_cnt_ff != 2'd0);
   assign rsp_blue      = q_ff[q_rd_ff].blue;
   assign rsp_green     = q_ff[q_rd_ff].green;
   assign rsp_red       = q_ff[q_rd_ff].red;
   assign rsp_out_col   = q_ff[q_rd_ff].col;
   assign rsp_out_row   = q_ff[q_rd_ff].row;
   assign rsp_frame_end = q_ff[q_rd_ff].fend;

   // checks
   `BBD_ASSERT_HOLDS(a_queue_bound, clock, reset, q_cnt_ff <= 2'd2, "output queue overflow")
   `BBD_ASSERT_HOLDS(a_col_range, clock, reset, int'(col_ff) < MAX_WIDTH, "column out of range")
   `BBD_ASSERT_IMPLIES(a_fwd_live, clock, reset, fwd_ff, s1_valid_ff, "bypass without pixel")
   `BBD_ASSERT_NEXT(a_push_shows, clock, reset, push && (q_cnt_ff == 2'd0), rsp_valid, "result lost")

endmodule

`default_nettype wire

/* verif/bayer_bilinear_demosaic_top_tb.sv */
// Self-checking testbench for bayer_bilinear_demosaic_top: streams raw Bayer frames under
// several register settings and compares every RGB transfer against a cycle-free predictor.
// Depends on bbd_pkg and the demosaic RTL.

module bayer_bilinear_demosaic_top_tb;

   localparam int PW            = bbd_pkg::PIXEL_W;
   localparam int COL_W         = $clog2(bbd_pkg::MAX_WIDTH_DEF);
   localparam int ROW_W         = $clog2(bbd_pkg::MAX_HEIGHT_DEF);
   localparam int CYCLE_LIMIT   = 1_500_000;
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_HOLD     = 200;
   localparam int NO_PAUSE      = -1;

   typedef struct packed {
      logic [PW-1:0]    blue;
      logic [PW-1:0]    green;
      logic [PW-1:0]    red;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic             frame_end;
   } rgb_pixel_type;

   // predicts the RGB stream from accepted raw pixels and checks result transfers
   class demosaic_board;
      bit [PW-1:0]   line_prev[bbd_pkg::MAX_WIDTH_DEF];
      bit [PW-1:0]   line_prev2[bbd_pkg::MAX_WIDTH_DEF];
      bit [PW-1:0]   win[3][3];   // [line][column]; line 2 and column 2 newest
      int unsigned   col_pos;
      int unsigned   row_pos;
      int unsigned   width_reg  = 32'(bbd_pkg::LINE_WIDTH_RST);
      int unsigned   height_reg = 32'(bbd_pkg::FRAME_HEIGHT_RST);
      bit [bbd_pkg::PHASE_W-1:0] phase_reg = bbd_pkg::BAYER_PHASE_RST;
      rgb_pixel_type rgb_due[$];
      int unsigned   fail_count;

      function void set_register(logic [1:0] idx, logic [bbd_pkg::CSR_DATA_W-1:0] value);
         case (idx)
            bbd_pkg::REG_LINE_WIDTH:
               width_reg  = 32'(value[bbd_pkg::LINE_WIDTH_W-1:0]);
            bbd_pkg::REG_FRAME_HEIGHT:
               height_reg = 32'(value[bbd_pkg::FRAME_HEIGHT_W-1:0]);
            bbd_pkg::REG_BAYER_PHASE:
               phase_reg  = value[bbd_pkg::PHASE_W-1:0];
            default: ;
         endcase
      endfunction

      // center, two-neighbor mean or diagonal mean, by distance to the color site
      function bit [PW-1:0] site_value(bit lx, bit ly);
         if (!lx && !ly) return win[1][1];
         if (!lx) return PW'((int'(win[0][1]) + int'(win[2][1])) >> 1);
         if (!ly) return PW'((int'(win[1][0]) + int'(win[1][2])) >> 1);
         return PW'((int'(win[0][0]) + int'(win[2][0]) + int'(win[0][2])
                    + int'(win[2][2])) >> 2);
      endfunction

      function void note_raw_pixel(bit [PW-1:0] px, bit first);
         int unsigned   w, h, c, r, cc, rr;
         bit [PW-1:0]   top, mid;
         bit            red_lx, red_ly;
         rgb_pixel_type res;
         w = (width_reg > bbd_pkg::MAX_WIDTH_DEF) ? bbd_pkg::MAX_WIDTH_DEF : width_reg;
         h = (height_reg > bbd_pkg::MAX_HEIGHT_DEF) ? bbd_pkg::MAX_HEIGHT_DEF : height_reg;
         if (first) begin
            col_pos = 0;
            row_pos = 0;
         end
         c = col_pos;
         r = row_pos;
         top = '0;
         mid = '0;
         if (c < bbd_pkg::MAX_WIDTH_DEF) begin
            top = line_prev2[c];
            mid = line_prev[c];
            line_prev2[c] = mid;
            line_prev[c]  = px;
         end
         for (int k = 0; k < 3; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
         end
         win[0][2] = top;
         win[1][2] = mid;
         win[2][2] = px;

         // window center is one column and one line behind the newest sample
         if (c >= 3 && c + 2 <= w && r >= 3 && r + 2 <= h) begin
            cc = c - 1;
            rr = r - 1;
            // red sits at column parity ~phase[0], row parity phase[1]; blue opposite
            red_lx = cc[0] ^ ~phase_reg[0];
            red_ly = rr[0] ^ phase_reg[1];
            res.red  = site_value(red_lx, red_ly);
            res.blue = site_value(~red_lx, ~red_ly);
            // green on the two sites off the red/blue diagonal
            if (red_lx ^ red_ly)
               res.green = win[1][1];
            else
               res.green = PW'((int'(win[0][1]) + int'(win[2][1]) + int'(win[1][0])
                               + int'(win[1][2])) >> 2);
            res.col       = cc[COL_W-1:0];
            res.row       = rr[ROW_W-1:0];
            res.frame_end = (c + 2 == w) && (r + 2 == h);
            rgb_due.push_back(res);
         end

         if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
         end else begin
            col_pos = c + 1;
         end
      endfunction

      function void compare(string tag, logic [31:0] want_v, logic [31:0] got_v);
         if (got_v !== want_v) begin
            $display("%0t: %s expected %0d, actual %0d", $time, tag, want_v, got_v);
            fail_count++;
         end
      endfunction

      function void check_rgb(rgb_pixel_type got);
         rgb_pixel_type want;
         if (rgb_due.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual col %0d row %0d",
                     $time, got.col, got.row);
            fail_count++;
            return;
         end
         want = rgb_due.pop_front();
         compare("blue", 32'(want.blue), 32'(got.blue));
         compare("green", 32'(want.green), 32'(got.green));
         compare("red", 32'(want.red), 32'(got.red));
         compare("out_col", 32'(want.col), 32'(got.col));
         compare("out_row", 32'(want.row), 32'(got.row));
         compare("frame_end", 32'(want.frame_end), 32'(got.frame_end));
      endfunction

      function int unsigned pending();
         return rgb_due.size();
      endfunction
   endclass

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_stall;
   logic [PW-1:0]                     req_raw_pixel;
   logic                              req_frame_start;
   logic                              rsp_valid;
   logic                              rsp_stall;
   logic [PW-1:0]                     rsp_blue;
   logic [PW-1:0]                     rsp_green;
   logic [PW-1:0]                     rsp_red;
   logic [COL_W-1:0]                  rsp_out_col;
   logic [ROW_W-1:0]                  rsp_out_row;
   logic                              rsp_frame_end;
   logic                              psel;
   logic                              penable;
   logic                              pwrite;
   logic [bbd_pkg::CSR_ADDR_W-1:0]    paddr;
   logic [bbd_pkg::CSR_DATA_W-1:0]    pwdata;
   logic [bbd_pkg::CSR_DATA_W-1:0]    prdata;
   logic                              pready;

   demosaic_board rgb_board;
   bit            sender_calm;
   bit            rsp_calm;
   bit            long_hold_due;
   int unsigned   cycle_count;

   bayer_bilinear_demosaic_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_raw_pixel   (req_raw_pixel),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_blue        (rsp_blue),
      .rsp_green       (rsp_green),
      .rsp_red         (rsp_red),
      .rsp_out_col     (rsp_out_col),
      .rsp_out_row     (rsp_out_row),
      .rsp_frame_end   (rsp_frame_end),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, rgb_board.pending());
         $display("bayer_bilinear_demosaic_top: mismatch");
         $finish;
      end
   end

   // feed every input transfer to the predictor
   always @(posedge clock) begin : req_monitor
      if (!reset && req_valid && !req_stall)
         rgb_board.note_raw_pixel(req_raw_pixel, req_frame_start);
   end

   // check every result transfer
   always @(posedge clock) begin : rsp_monitor
      if (!reset && rsp_valid && !rsp_stall)
         rgb_board.check_rgb({rsp_blue, rsp_green, rsp_red, rsp_out_col, rsp_out_row,
                              rsp_frame_end});
   end

   function automatic int unsigned draw_gap(bit calm);
      if (calm || $urandom_range(0, 1) == 0) return 0;
      return $urandom_range(1, 10);
   endfunction

   function automatic bit [PW-1:0] pick_pixel();
      if ($urandom_range(0, 6) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      return PW'($urandom_range(0, 255));
   endfunction

   // receiver: random stall before each transfer, one long hold on request
   initial begin : rsp_side
      int unsigned hold;
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            hold = LONG_HOLD;
         end else begin
            hold = draw_gap(rsp_calm);
         end
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_pixel(bit [PW-1:0] px, bit first);
      int unsigned gap;
      gap = draw_gap(sender_calm);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_raw_pixel   <= px;
      req_frame_start <= first;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // stop sending and wait for all outstanding results, then let the pipe empty
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (rgb_board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [bbd_pkg::CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= bbd_pkg::CSR_ADDR_W'(idx) << 2;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      rgb_board.set_register(idx, value);
      @(posedge clock);
   endtask

   task automatic configure(int unsigned lw, int unsigned fh, int unsigned ph);
      csr_write(bbd_pkg::REG_LINE_WIDTH, lw);
      csr_write(bbd_pkg::REG_FRAME_HEIGHT, fh);
      csr_write(bbd_pkg::REG_BAYER_PHASE, ph);
   endtask

   // raster stream: frame_start on most frame starts, now and then mid-frame or dropped
   task automatic stream_frames(int unsigned lw, int unsigned fh, int unsigned count,
                                int pause_at);
      int unsigned w_eff, h_eff, frame_len, pos;
      bit          first;
      w_eff = (lw > bbd_pkg::MAX_WIDTH_DEF) ? bbd_pkg::MAX_WIDTH_DEF : ((lw == 0) ? 1 : lw);
      h_eff = (fh > bbd_pkg::MAX_HEIGHT_DEF) ? bbd_pkg::MAX_HEIGHT_DEF : ((fh == 0) ? 1 : fh);
      frame_len = w_eff * h_eff;
      pos = 0;
      for (int i = 0; i < count; i++) begin
         if (i == pause_at) settle();
         first = (i == 0) || (pos == 0 && $urandom_range(0, 9) != 0) ||
                 ($urandom_range(0, 49) == 0);
         if (first) pos = 0;
         send_pixel(pick_pixel(), first);
         pos = (pos + 1 == frame_len) ? 0 : pos + 1;
      end
   endtask

   initial begin : stimulus
      int unsigned lw, fh;
      rgb_board = new();
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_raw_pixel   <= '0;
      req_frame_start <= 1'b0;
      psel            <= 1'b0;
      penable         <= 1'b0;
      pwrite          <= 1'b0;
      paddr           <= '0;
      pwdata          <= '0;
      sender_calm = 1'b1;
      rsp_calm    = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // smallest frame: one interior pixel, extreme values around it
      configure(5, 5, 0);
      for (int i = 0; i < 25; i++)
         send_pixel((i % 3 == 0) ? 8'hFF : ((i % 3 == 1) ? 8'h00 : 8'h7F), i == 0);

      // small frames in all four phases; undersized and oversized heights mixed in
      for (int k = 0; k < 12; k++) begin
         settle();
         case ($urandom_range(0, 7))
            0:       lw = $urandom_range(0, 4);
            default: lw = $urandom_range(5, 16);
         endcase
         case ($urandom_range(0, 7))
            0:       fh = $urandom_range(0, 4);
            1:       fh = $urandom_range(bbd_pkg::MAX_HEIGHT_DEF + 1, 8191);
            default: fh = $urandom_range(5, 12);
         endcase
         sender_calm = ($urandom_range(0, 3) == 0);
         rsp_calm    = ($urandom_range(0, 3) == 0);
         configure(lw, fh, k % 4);
         stream_frames(lw, fh, 75, NO_PAUSE);
      end

      // back-pressure: long receiver hold while pixels keep coming, then a full drain
      settle();
      sender_calm   = 1'b1;
      rsp_calm      = 1'b0;
      configure(8, 8, 1);
      long_hold_due = 1'b1;
      stream_frames(8, 8, 300, 150);

      // width register beyond the line store: first pixels of the widest line
      settle();
      sender_calm = ($urandom_range(0, 1) == 0);
      rsp_calm    = ($urandom_range(0, 1) == 0);
      configure(4095, 5, 3);
      stream_frames(4095, 5, 160, NO_PAUSE);

      // height register beyond the limit: first rows of the tallest frame
      settle();
      configure(5, 8191, 2);
      stream_frames(5, 8191, 160, NO_PAUSE);

      settle();
      if (rgb_board.fail_count == 0)
         $display("bayer_bilinear_demosaic_top: match");
      else
         $display("bayer_bilinear_demosaic_top: mismatch");
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/bbd_pkg.sv
rtl/core/bbd_ram.sv
rtl/core/bbd_csr.sv
rtl/core/bbd_window.sv
rtl/core/bayer_bilinear_demosaic_top.sv
verif/bayer_bilinear_demosaic_top_tb.sv
